### rtl/core/mrrf_pkg.sv
package mrrf_pkg;

    localparam int unsigned FRAME_IDX_W = 4;
    localparam int unsigned BIT_CNT_W   = 3;
    localparam int unsigned ADDR_W      = 4;
    localparam int unsigned DATA_W      = 32;

    localparam logic [7:0]  DEV_ADDR_RST  = 8'h01;
    localparam logic [15:0] CRC_POLY_RST  = 16'hA001;
    localparam logic [15:0] CRC_START_RST = 16'hFFFF;

    localparam logic [15:0] MULT_REG_COUNT  = 16'h0002;
    localparam logic [7:0]  MULT_BYTE_COUNT = 8'h04;

    // last body byte index per frame type
    localparam logic [FRAME_IDX_W-1:0] SINGLE_BODY_LAST = 4'd5;
    localparam logic [FRAME_IDX_W-1:0] MULT_BODY_LAST   = 4'd10;

    localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = 3'd7;

    typedef enum logic [1:0] {
        REG_DEV_ADDR  = 2'd0,
        REG_CRC_POLY  = 2'd1,
        REG_CRC_START = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_SHIFT,
        ST_CRC_LO,
        ST_CRC_HI
    } state_t;

    function automatic logic [15:0] crc_bit_step(input logic [15:0] crc,
                                                 input logic [15:0] poly);
        logic [15:0] shifted;
        begin
            shifted = {1'b0, crc[15:1]};
            crc_bit_step = crc[0] ? (shifted ^ poly) : shifted;
        end
    endfunction

    function automatic logic [7:0] body_byte(input logic                   mode,
                                             input logic [FRAME_IDX_W-1:0] idx,
                                             input logic [7:0]             dev,
                                             input logic [7:0]             func,
                                             input logic [15:0]            addr,
                                             input logic [15:0]            v1,
                                             input logic [15:0]            v2);
        logic [7:0] b;
        begin
            b = 8'h00;
            case (idx)
                4'd0: b = dev;
                4'd1: b = func;
                4'd2: b = addr[15:8];
                4'd3: b = addr[7:0];
                4'd4: b = mode ? MULT_REG_COUNT[15:8] : v1[15:8];
                4'd5: b = mode ? MULT_REG_COUNT[7:0]  : v1[7:0];
                4'd6: b = MULT_BYTE_COUNT;
                4'd7: b = v1[15:8];
                4'd8: b = v1[7:0];
                4'd9: b = v2[15:8];
                4'd10: b = v2[7:0];
                default: b = 8'h00;
            endcase
            body_byte = b;
        end
    endfunction

endpackage

### rtl/core/modbus_rtu_request_framer_top.sv
// Modbus RTU request framer. One request transaction on the input yields an
// 8-byte (mode 0) or 13-byte (mode 1) frame on the output, one byte per
// output transaction, last_byte set on the high CRC byte. The CRC-16 is
// built by a single shift/xor unit stepping one bit per cycle, so each body
// byte takes one mix step and eight shift steps; the mix step, like the
// CRC byte steps, waits while the output is stalled. The input is not ready
// until the frame's last byte has been loaded. Device address, polynomial
// and start value are APB registers at 0x0, 0x4 and 0x8, reset to Modbus
// defaults.
module modbus_rtu_request_framer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mrrf_pkg::ADDR_W-1:0] paddr,
    input  logic [mrrf_pkg::DATA_W-1:0] pwdata,
    output logic [mrrf_pkg::DATA_W-1:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  function_code,
    input  logic [15:0] register_address,
    input  logic [15:0] first_value,
    input  logic [15:0] second_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    logic [7:0]  dev_addr_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_start_reg;

    mrrf_pkg::state_t state_reg, state_next;

    logic        mode_reg;
    logic [7:0]  func_reg;
    logic [15:0] addr_reg;
    logic [15:0] v1_reg;
    logic [15:0] v2_reg;

    logic [15:0] crc_reg, crc_next;
    logic [mrrf_pkg::FRAME_IDX_W-1:0] idx_reg, idx_next;
    logic [mrrf_pkg::BIT_CNT_W-1:0]   bit_reg, bit_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic        in_fire;
    logic        slot_free;
    logic        cfg_wr;
    logic [7:0]  cur_byte;
    logic [mrrf_pkg::FRAME_IDX_W-1:0] body_last;
    mrrf_pkg::reg_idx_t reg_sel;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign reg_sel   = mrrf_pkg::reg_idx_t'(paddr[3:2]);

    assign in_ready  = (state_reg == mrrf_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign last_byte  = out_last_reg;

    assign body_last = mode_reg ? mrrf_pkg::MULT_BODY_LAST : mrrf_pkg::SINGLE_BODY_LAST;
    assign cur_byte  = mrrf_pkg::body_byte(mode_reg, idx_reg, dev_addr_reg, func_reg,
                                           addr_reg, v1_reg, v2_reg);

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            mrrf_pkg::REG_DEV_ADDR:  prdata = {24'h0, dev_addr_reg};
            mrrf_pkg::REG_CRC_POLY:  prdata = {16'h0, crc_poly_reg};
            mrrf_pkg::REG_CRC_START: prdata = {16'h0, crc_start_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= mrrf_pkg::DEV_ADDR_RST;
            crc_poly_reg  <= mrrf_pkg::CRC_POLY_RST;
            crc_start_reg <= mrrf_pkg::CRC_START_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                mrrf_pkg::REG_DEV_ADDR:  dev_addr_reg  <= pwdata[7:0];
                mrrf_pkg::REG_CRC_POLY:  crc_poly_reg  <= pwdata[15:0];
                mrrf_pkg::REG_CRC_START: crc_start_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrrf_pkg::ST_IDLE:
                if (in_fire)
                    state_next = mrrf_pkg::ST_MIX;
            mrrf_pkg::ST_MIX:
                if (slot_free)
                    state_next = mrrf_pkg::ST_SHIFT;
            mrrf_pkg::ST_SHIFT:
                if (bit_reg == mrrf_pkg::BIT_CNT_LAST)
                    state_next = (idx_reg == body_last) ? mrrf_pkg::ST_CRC_LO
                                                        : mrrf_pkg::ST_MIX;
            mrrf_pkg::ST_CRC_LO:
                if (slot_free)
                    state_next = mrrf_pkg::ST_CRC_HI;
            mrrf_pkg::ST_CRC_HI:
                if (slot_free)
                    state_next = mrrf_pkg::ST_IDLE;
            default:
                state_next = mrrf_pkg::ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        crc_next       = crc_reg;
        idx_next       = idx_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            mrrf_pkg::ST_IDLE:
                if (in_fire)
                begin
                    crc_next = crc_start_reg;
                    idx_next = '0;
                end
            mrrf_pkg::ST_MIX:
                if (slot_free)
                begin
                    crc_next       = crc_reg ^ {8'h00, cur_byte};
                    bit_next       = '0;
                    out_valid_next = 1'b1;
                    out_byte_next  = cur_byte;
                    out_last_next  = 1'b0;
                end
            mrrf_pkg::ST_SHIFT:
            begin
                crc_next = mrrf_pkg::crc_bit_step(crc_reg, crc_poly_reg);
                bit_next = bit_reg + 1'b1;
                if (bit_reg == mrrf_pkg::BIT_CNT_LAST)
                    idx_next = idx_reg + 1'b1;
            end
            mrrf_pkg::ST_CRC_LO:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_reg[7:0];
                    out_last_next  = 1'b0;
                end
            mrrf_pkg::ST_CRC_HI:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_reg[15:8];
                    out_last_next  = 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrrf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            bit_reg       <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (in_fire)
        begin
            mode_reg <= mode;
            func_reg <= function_code;
            addr_reg <= register_address;
            v1_reg   <= first_value;
            v2_reg   <= second_value;
        end
    end

endmodule

### rtl/core/mrrf_checker.sv
module mrrf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] frame_byte,
    input logic       last_byte
);

    // stalled output holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
        else $error("output changed while stalled");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready straight after a transaction");

    // while idle only the final CRC byte may still be pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last_byte)
        else $error("input ready with a non-final byte pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind modbus_rtu_request_framer_top mrrf_checker u_mrrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame_byte(frame_byte),
    .last_byte (last_byte)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic MODE_SINGLE = 1'b0;
    localparam logic MODE_MULTI  = 1'b1;

    localparam int unsigned SETTLE_CYCLES = 30;
    localparam longint unsigned RUN_LIMIT_NS = 64'd10_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mrrf_pkg::ADDR_W-1:0]   paddr;
    logic [mrrf_pkg::DATA_W-1:0]   pwdata;
    logic [mrrf_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic                          mode;
    logic [7:0]                    function_code;
    logic [15:0]                   register_address;
    logic [15:0]                   first_value;
    logic [15:0]                   second_value;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [7:0]                    frame_byte;
    logic                          last_byte;

    // shadow copy of the block's registers
    logic [7:0]  dev_addr_r;
    logic [15:0] crc_poly_r;
    logic [15:0] crc_seed_r;

    wire_byte_t  wire_q[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    modbus_rtu_request_framer_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .function_code    (function_code),
        .register_address (register_address),
        .first_value      (first_value),
        .second_value     (second_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .frame_byte       (frame_byte),
        .last_byte        (last_byte)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                    input logic [7:0]  data);
        logic [15:0] c;
        int          b;
        begin
            c = crc ^ {8'h00, data};
            for (b = 0; b < 8; b++)
                c = c[0] ? ({1'b0, c[15:1]} ^ crc_poly_r) : {1'b0, c[15:1]};
            return c;
        end
    endfunction

    function automatic void predict_frame(input logic        m,
                                          input logic [7:0]  func,
                                          input logic [15:0] addr,
                                          input logic [15:0] v1,
                                          input logic [15:0] v2);
        logic [7:0]  body[13];
        int          body_len;
        int          k;
        logic [15:0] crc;
        wire_byte_t  wb;
        begin
            body[0] = dev_addr_r;
            body[1] = func;
            body[2] = addr[15:8];
            body[3] = addr[7:0];
            if (m == MODE_SINGLE)
            begin
                body[4]  = v1[15:8];
                body[5]  = v1[7:0];
                body_len = 6;
            end
            else
            begin
                body[4]  = mrrf_pkg::MULT_REG_COUNT[15:8];
                body[5]  = mrrf_pkg::MULT_REG_COUNT[7:0];
                body[6]  = mrrf_pkg::MULT_BYTE_COUNT;
                body[7]  = v1[15:8];
                body[8]  = v1[7:0];
                body[9]  = v2[15:8];
                body[10] = v2[7:0];
                body_len = 11;
            end
            crc = crc_seed_r;
            for (k = 0; k < body_len; k++)
                crc = crc_byte_update(crc, body[k]);
            body[body_len]     = crc[7:0];
            body[body_len + 1] = crc[15:8];
            for (k = 0; k < body_len + 2; k++)
            begin
                wb.data = body[k];
                wb.last = (k == body_len + 1);
                wire_q.push_back(wb);
            end
        end
    endfunction

    function automatic logic [15:0] pick16();
        logic [15:0] v;
        begin
            case ($urandom_range(0, 9))
                0: v = 16'h0000;
                1: v = 16'hFFFF;
                default: v = 16'($urandom);
            endcase
            return v;
        end
    endfunction

    always @(posedge clk)
    begin
        wire_byte_t exp_b;
        if (rst_n && out_valid && out_ready)
        begin
            if (wire_q.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, actual %h last %b",
                         $time, frame_byte, last_byte);
                fail_count++;
            end
            else
            begin
                exp_b = wire_q.pop_front();
                if (frame_byte !== exp_b.data)
                begin
                    $display("%0t: frame_byte expected %h actual %h",
                             $time, exp_b.data, frame_byte);
                    fail_count++;
                end
                if (last_byte !== exp_b.last)
                begin
                    $display("%0t: last_byte expected %b actual %b",
                             $time, exp_b.last, last_byte);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(input logic        m,
                                input logic [7:0]  func,
                                input logic [15:0] addr,
                                input logic [15:0] v1,
                                input logic [15:0] v2);
        begin
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid = 1'b0;
                mode             = 1'($urandom);
                function_code    = 8'($urandom);
                register_address = 16'($urandom);
                first_value      = 16'($urandom);
                second_value     = 16'($urandom);
                @(negedge clk);
            end
            mode             = m;
            function_code    = func;
            register_address = addr;
            first_value      = v1;
            second_value     = v2;
            in_valid         = 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_frame(m, func, addr, v1, v2);
        end
    endtask

    task automatic send_random_request();
        logic [7:0] func;
        begin
            func = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
            send_request(1'($urandom), func, pick16(), pick16(), pick16());
        end
    endtask

    // let the output queue empty and the block go idle
    task automatic drain();
        begin
            @(negedge clk);
            in_valid = 1'b0;
            while (wire_q.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic reg_write(input mrrf_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] expected;
        begin
            @(negedge clk);
            psel    = 1'b1;
            penable = 1'b0;
            pwrite  = 1'b1;
            paddr   = {idx, 2'b00};
            pwdata  = value;
            @(negedge clk);
            penable = 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            case (idx)
                mrrf_pkg::REG_DEV_ADDR:  dev_addr_r = value[7:0];
                mrrf_pkg::REG_CRC_POLY:  crc_poly_r = value[15:0];
                mrrf_pkg::REG_CRC_START: crc_seed_r = value[15:0];
                default: ;
            endcase
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
            pwrite  = 1'b0;
            if (idx != mrrf_pkg::REG_NONE)
            begin
                case (idx)
                    mrrf_pkg::REG_DEV_ADDR:  expected = {24'h0, dev_addr_r};
                    mrrf_pkg::REG_CRC_POLY:  expected = {16'h0, crc_poly_r};
                    default:                 expected = {16'h0, crc_seed_r};
                endcase
                psel  = 1'b1;
                paddr = {idx, 2'b00};
                @(negedge clk);
                penable = 1'b1;
                @(posedge clk);
                while (!pready)
                    @(posedge clk);
                if (prdata !== expected)
                begin
                    $display("%0t: readback of %s expected %h actual %h",
                             $time, idx.name(), expected, prdata);
                    fail_count++;
                end
                @(negedge clk);
                psel    = 1'b0;
                penable = 1'b0;
            end
        end
    endtask

    task automatic set_crc_config(input logic [7:0]  dev,
                                  input logic [15:0] poly,
                                  input logic [15:0] seed);
        begin
            drain();
            reg_write(mrrf_pkg::REG_DEV_ADDR,
                      {$urandom_range(0, 1) ? 24'h0 : 24'($urandom), dev});
            reg_write(mrrf_pkg::REG_CRC_POLY,
                      {$urandom_range(0, 1) ? 16'h0 : 16'($urandom), poly});
            reg_write(mrrf_pkg::REG_CRC_START,
                      {$urandom_range(0, 1) ? 16'h0 : 16'($urandom), seed});
        end
    endtask

    // reset values, frame layouts, field extremes
    task automatic test_frame_layout();
        begin
            send_request(MODE_SINGLE, 8'h06, 16'h0001, 16'h0003, 16'h0000);
            send_request(MODE_MULTI,  8'h10, 16'h0002, 16'h1234, 16'hABCD);
            send_request(MODE_SINGLE, 8'h00, 16'h0000, 16'h0000, 16'h0000);
            send_request(MODE_SINGLE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            send_request(MODE_MULTI,  8'h00, 16'h0000, 16'h0000, 16'h0000);
            send_request(MODE_MULTI,  8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            send_request(MODE_MULTI,  8'h5A, 16'hA55A, 16'h00FF, 16'hFF00);
        end
    endtask

    // second value must not affect a single-register frame
    task automatic test_unused_second_value();
        begin
            send_request(MODE_SINGLE, 8'h03, 16'h1000, 16'h0002, 16'h0000);
            send_request(MODE_SINGLE, 8'h03, 16'h1000, 16'h0002, 16'hFFFF);
            send_request(MODE_SINGLE, 8'h03, 16'h1000, 16'h0002, 16'h5AA5);
        end
    endtask

    // odd function codes keep the layout
    task automatic test_function_codes();
        begin
            send_request(MODE_SINGLE, 8'h80, 16'h0102, 16'h0304, 16'h0506);
            send_request(MODE_MULTI,  8'h01, 16'h0102, 16'h0304, 16'h0506);
            send_request(MODE_MULTI,  8'h7F, 16'h8000, 16'h0001, 16'h8000);
        end
    endtask

    task automatic test_crc_settings();
        begin
            set_crc_config(8'h00, 16'h0000, 16'h0000);
            send_request(MODE_SINGLE, 8'h06, 16'h0001, 16'h0003, 16'h0000);
            send_request(MODE_MULTI,  8'h10, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            set_crc_config(8'hFF, 16'hFFFF, 16'hFFFF);
            send_request(MODE_SINGLE, 8'h06, 16'h0001, 16'h0003, 16'h0000);
            send_request(MODE_MULTI,  8'h10, 16'h0000, 16'h0000, 16'h0000);
            set_crc_config(8'h11, 16'h8408, 16'h0000);
            send_request(MODE_SINGLE, 8'h04, 16'h0010, 16'h0008, 16'h0000);
            send_request(MODE_MULTI,  8'h10, 16'h0010, 16'hBEEF, 16'hCAFE);
        end
    endtask

    task automatic test_unmapped_register();
        begin
            drain();
            reg_write(mrrf_pkg::REG_NONE, 32'hFFFF_FFFF);
            send_request(MODE_SINGLE, 8'h06, 16'h0001, 16'h0003, 16'h0000);
            send_request(MODE_MULTI,  8'h10, 16'h0001, 16'h0003, 16'h0004);
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int n;
        begin
            drain();
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            for (n = 0; n < count; n++)
                send_random_request();
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        mode             = MODE_SINGLE;
        function_code    = 8'h00;
        register_address = 16'h0000;
        first_value      = 16'h0000;
        second_value     = 16'h0000;
        dev_addr_r       = mrrf_pkg::DEV_ADDR_RST;
        crc_poly_r       = mrrf_pkg::CRC_POLY_RST;
        crc_seed_r       = mrrf_pkg::CRC_START_RST;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_frame_layout();
        test_unused_second_value();
        test_function_codes();
        test_crc_settings();
        test_unmapped_register();

        set_crc_config(mrrf_pkg::DEV_ADDR_RST, mrrf_pkg::CRC_POLY_RST,
                       mrrf_pkg::CRC_START_RST);
        test_random_traffic(0, 0, 100);
        set_crc_config(8'($urandom), 16'($urandom), 16'($urandom));
        test_random_traffic(49, 0, 100);
        set_crc_config(8'hFF, 16'hFFFF, 16'h0000);
        test_random_traffic(0, 49, 100);
        set_crc_config(8'($urandom), 16'($urandom), 16'($urandom));
        test_random_traffic(16, 16, 100);

        drain();
        if (fail_count == 0 && wire_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: errors");
        $finish;
    end

endmodule

### files.f
rtl/core/mrrf_pkg.sv
rtl/core/modbus_rtu_request_framer_top.sv
rtl/core/mrrf_checker.sv
tb/sv/tb.sv
